### src/fdsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsc_pkg
// Types and constants shared by the frame deframer with additive checksum.
// ----------------------------------------------------------------------------
package fdsc_pkg;

   // header layout
   localparam int unsigned HEADER_BYTES = 5;
   localparam int unsigned POS_W        = 9;
   localparam int unsigned COUNT_W      = POS_W + 1;
   localparam logic [POS_W-1:0] POSITION_MAX = {POS_W{1'b1}};

   // header byte positions
   localparam logic [POS_W-1:0] POS_MARKER   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LENGTH   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_SEQUENCE = POS_W'(2);
   localparam logic [POS_W-1:0] POS_KIND     = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(4);

   // frame status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_SHORT     = 3'd1;
   localparam logic [2:0] STATUS_BAD_MARK  = 3'd2;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;
   localparam logic [2:0] STATUS_CHECKSUM  = 3'd5;

   // control register indexes and reset values
   localparam logic CSR_START_MARKER = 1'b0;
   localparam logic CSR_MAX_PAYLOAD  = 1'b1;
   localparam logic [7:0] START_MARKER_RESET = 8'd126;
   localparam logic [7:0] MAX_PAYLOAD_RESET  = 8'd64;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       frame_done;
      logic [2:0] frame_status;
      logic [7:0] frame_length;
      logic [7:0] frame_sequence;
      logic [7:0] frame_kind;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] max_payload;
   } cfg_type;

endpackage

### src/frame_deframer_sum_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_sum_checksum
// Length-prefixed frame parser with an additive 8-bit checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer, with buffer_end set on the
//   last byte of a buffer. Every input transfer yields exactly one rsp_*
//   transfer: payload bytes are flagged by payload_valid, and on the last
//   byte frame_done is set with the status and header fields.
//   The result of a byte sits in the output register in the cycle after its
//   transfer. Throughput is one byte per cycle while the receiver does not
//   stall; the parser state update (compare, 8-bit add, position count) is
//   combinational, so bytes can follow back to back.
//   When the receiver stalls, the output register holds its result and
//   req_stall rises only while a result is waiting and rsp_stall is high;
//   a new byte is taken in the same cycle the held result leaves.
//   csr_* writes start_marker (index 0) and max_payload (index 1); writes
//   take effect from the next byte. Synchronous reset clears the parser and
//   the output valid flag, and sets start_marker to 126 and max_payload to 64.
// ----------------------------------------------------------------------------
module frame_deframer_sum_checksum (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fdsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fdsc_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);

   fdsc_pkg::cfg_type cfg_ff;
   fdsc_pkg::rsp_type result;
   fdsc_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              req_take;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= fdsc_pkg::START_MARKER_RESET;
         cfg_ff.max_payload  <= fdsc_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            fdsc_pkg::CSR_START_MARKER: cfg_ff.start_marker <= csr_wdata;
            fdsc_pkg::CSR_MAX_PAYLOAD:  cfg_ff.max_payload  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input transfer when the output slot is free or leaving
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   fdsc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (req_take),
      .req     (req_data),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every input transfer shows up in the output register next cycle
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("input transfer without a result");

   // a held result is not overwritten while the receiver stalls
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // status and header fields stay zero outside the end of a buffer
   a_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.frame_done) |->
      (rsp_data.frame_status == fdsc_pkg::STATUS_OK &&
       rsp_data.frame_length == 8'd0 && rsp_data.frame_sequence == 8'd0 &&
       rsp_data.frame_kind == 8'd0))
      else $error("frame fields set without frame_done");

   // on the last byte, a payload byte is never passed on for a short, bad-marker or too-long frame
   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.payload_valid && rsp_data.frame_done) |->
      (rsp_data.frame_status != fdsc_pkg::STATUS_SHORT &&
       rsp_data.frame_status != fdsc_pkg::STATUS_BAD_MARK &&
       rsp_data.frame_status != fdsc_pkg::STATUS_TOO_LONG))
      else $error("payload passed on for a rejected frame");

endmodule

### src/fdsc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsc_parser
// Byte-wise frame parser: holds position, header fields and running sum,
// and forms the result for the byte presented on req.
// ----------------------------------------------------------------------------
module fdsc_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fdsc_pkg::req_type req,
   input  fdsc_pkg::cfg_type cfg,
   output fdsc_pkg::rsp_type result
);

   logic [fdsc_pkg::POS_W-1:0] position_ff, position_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sequence_ff, sequence_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] received_ff, received_in;
   logic [7:0] sum_ff, sum_in;
   logic       marker_bad_ff, marker_bad_in;

   // values after this byte, before the end-of-buffer clear
   logic [7:0] length_upd, sequence_upd, kind_upd, received_upd, sum_upd;
   logic       marker_bad_upd;
   logic       in_payload, add_byte, pay;
   logic [fdsc_pkg::POS_W-1:0]   pay_offset;
   logic [fdsc_pkg::COUNT_W-1:0] count, needed;
   logic [2:0] status;

   // payload window check
   assign pay_offset = position_ff - fdsc_pkg::POS_W'(fdsc_pkg::HEADER_BYTES);
   assign in_payload = (position_ff >= fdsc_pkg::POS_W'(fdsc_pkg::HEADER_BYTES)) &&
                       (pay_offset < {1'b0, length_ff});
   assign pay = in_payload && !marker_bad_ff && (length_ff <= cfg.max_payload);

   // header capture and checksum byte selection
   always_comb begin
      length_upd     = length_ff;
      sequence_upd   = sequence_ff;
      kind_upd       = kind_ff;
      received_upd   = received_ff;
      marker_bad_upd = marker_bad_ff;
      add_byte       = 1'b0;
      unique case (position_ff)
         fdsc_pkg::POS_MARKER: begin
            marker_bad_upd = (req.rx_byte != cfg.start_marker);
         end
         fdsc_pkg::POS_LENGTH: begin
            length_upd = req.rx_byte;
            add_byte   = 1'b1;
         end
         fdsc_pkg::POS_SEQUENCE: begin
            sequence_upd = req.rx_byte;
            add_byte     = 1'b1;
         end
         fdsc_pkg::POS_KIND: begin
            kind_upd = req.rx_byte;
            add_byte = 1'b1;
         end
         fdsc_pkg::POS_CHECKSUM: begin
            received_upd = req.rx_byte;
         end
         default: begin
            add_byte = in_payload;
         end
      endcase
   end

   assign sum_upd = add_byte ? (sum_ff + req.rx_byte) : sum_ff;

   // status, first failing check wins
   assign count  = {1'b0, position_ff} + fdsc_pkg::COUNT_W'(1);
   assign needed = fdsc_pkg::COUNT_W'(fdsc_pkg::HEADER_BYTES) +
                   {{(fdsc_pkg::COUNT_W-8){1'b0}}, length_upd};

   always_comb begin
      priority if (count < fdsc_pkg::COUNT_W'(fdsc_pkg::HEADER_BYTES)) begin
         status = fdsc_pkg::STATUS_SHORT;
      end else if (marker_bad_upd) begin
         status = fdsc_pkg::STATUS_BAD_MARK;
      end else if (length_upd > cfg.max_payload) begin
         status = fdsc_pkg::STATUS_TOO_LONG;
      end else if (count < needed) begin
         status = fdsc_pkg::STATUS_TRUNCATED;
      end else if (sum_upd != received_upd) begin
         status = fdsc_pkg::STATUS_CHECKSUM;
      end else begin
         status = fdsc_pkg::STATUS_OK;
      end
   end

   // result for this byte
   always_comb begin
      result.payload_valid  = pay;
      result.payload_byte   = pay ? req.rx_byte : 8'd0;
      result.frame_done     = req.buffer_end;
      result.frame_status   = req.buffer_end ? status : fdsc_pkg::STATUS_OK;
      result.frame_length   = req.buffer_end ? length_upd : 8'd0;
      result.frame_sequence = req.buffer_end ? sequence_upd : 8'd0;
      result.frame_kind     = req.buffer_end ? kind_upd : 8'd0;
   end

   // next state, cleared at end of buffer
   always_comb begin
      if (req.buffer_end) begin
         position_in   = '0;
         length_in     = '0;
         sequence_in   = '0;
         kind_in       = '0;
         received_in   = '0;
         sum_in        = '0;
         marker_bad_in = 1'b0;
      end else begin
         position_in   = (position_ff < fdsc_pkg::POSITION_MAX) ?
                         position_ff + fdsc_pkg::POS_W'(1) : position_ff;
         length_in     = length_upd;
         sequence_in   = sequence_upd;
         kind_in       = kind_upd;
         received_in   = received_upd;
         sum_in        = sum_upd;
         marker_bad_in = marker_bad_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         length_ff     <= '0;
         sequence_ff   <= '0;
         kind_ff       <= '0;
         received_ff   <= '0;
         sum_ff        <= '0;
         marker_bad_ff <= 1'b0;
      end else if (advance) begin
         position_ff   <= position_in;
         length_ff     <= length_in;
         sequence_ff   <= sequence_in;
         kind_ff       <= kind_in;
         received_ff   <= received_in;
         sum_ff        <= sum_in;
         marker_bad_ff <= marker_bad_in;
      end
   end

endmodule

### verif/frame_deframer_sum_checksum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_deframer_sum_checksum_tb
// Self-checking bench for the length-prefixed frame parser. Buffers are sent
// one byte per transfer under several start marker and payload limit
// settings. An in-bench parser predicts every result transfer, and each
// result is compared field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module frame_deframer_sum_checksum_tb;

   // predicts parser results and checks them in order
   class deframer_scoreboard;
      logic [7:0]                 marker_cfg;
      logic [7:0]                 limit_cfg;
      logic [fdsc_pkg::POS_W-1:0] position;
      logic [7:0]                 length_hdr;
      logic [7:0]                 seq_hdr;
      logic [7:0]                 kind_hdr;
      logic [7:0]                 sent_csum;
      logic [7:0]                 csum_acc;
      bit                         marker_wrong;
      fdsc_pkg::rsp_type          result_q[$];
      int unsigned                errors;
      int unsigned                bytes_seen;
      int unsigned                buffers_seen;
      int unsigned                status_count[6];

      function new();
         marker_cfg = fdsc_pkg::START_MARKER_RESET;
         limit_cfg = fdsc_pkg::MAX_PAYLOAD_RESET;
         errors = 0;
         bytes_seen = 0;
         buffers_seen = 0;
         foreach (status_count[i]) status_count[i] = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         position = '0;
         length_hdr = '0;
         seq_hdr = '0;
         kind_hdr = '0;
         sent_csum = '0;
         csum_acc = '0;
         marker_wrong = 0;
      endfunction

      function void set_reg(logic idx, logic [7:0] value);
         if (idx == fdsc_pkg::CSR_START_MARKER) begin
            marker_cfg = value;
         end else begin
            limit_cfg = value;
         end
      endfunction

      // note an accepted byte and queue the result it must produce
      function void note_byte(fdsc_pkg::req_type r);
         fdsc_pkg::rsp_type            want;
         logic [fdsc_pkg::COUNT_W-1:0] count;
         want = '0;
         case (position)
            fdsc_pkg::POS_MARKER: marker_wrong = (r.rx_byte != marker_cfg);
            fdsc_pkg::POS_LENGTH: begin
               length_hdr = r.rx_byte;
               csum_acc += r.rx_byte;
            end
            fdsc_pkg::POS_SEQUENCE: begin
               seq_hdr = r.rx_byte;
               csum_acc += r.rx_byte;
            end
            fdsc_pkg::POS_KIND: begin
               kind_hdr = r.rx_byte;
               csum_acc += r.rx_byte;
            end
            fdsc_pkg::POS_CHECKSUM: sent_csum = r.rx_byte;
            default: begin
               // payload bytes only; anything past the payload is ignored
               if (position - fdsc_pkg::POS_W'(fdsc_pkg::HEADER_BYTES) <
                   {1'b0, length_hdr}) begin
                  csum_acc += r.rx_byte;
                  if (!marker_wrong && length_hdr <= limit_cfg) begin
                     want.payload_valid = 1'b1;
                     want.payload_byte = r.rx_byte;
                  end
               end
            end
         endcase
         count = fdsc_pkg::COUNT_W'(position) + 1'b1;
         if (position != fdsc_pkg::POSITION_MAX) position = position + 1'b1;
         if (r.buffer_end) begin
            // status priority: short, marker, limit, truncated, checksum
            want.frame_done = 1'b1;
            if (count < fdsc_pkg::COUNT_W'(fdsc_pkg::HEADER_BYTES)) begin
               want.frame_status = fdsc_pkg::STATUS_SHORT;
            end else if (marker_wrong) begin
               want.frame_status = fdsc_pkg::STATUS_BAD_MARK;
            end else if (length_hdr > limit_cfg) begin
               want.frame_status = fdsc_pkg::STATUS_TOO_LONG;
            end else if (count < fdsc_pkg::COUNT_W'(fdsc_pkg::HEADER_BYTES) +
                                 fdsc_pkg::COUNT_W'(length_hdr)) begin
               want.frame_status = fdsc_pkg::STATUS_TRUNCATED;
            end else if (csum_acc != sent_csum) begin
               want.frame_status = fdsc_pkg::STATUS_CHECKSUM;
            end else begin
               want.frame_status = fdsc_pkg::STATUS_OK;
            end
            want.frame_length = length_hdr;
            want.frame_sequence = seq_hdr;
            want.frame_kind = kind_hdr;
            clear_parse();
         end
         result_q.push_back(want);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // compare a result transfer with the oldest prediction
      function void check_result(fdsc_pkg::rsp_type got);
         fdsc_pkg::rsp_type want;
         if (result_q.size() == 0) begin
            $error("result transfer with no byte outstanding");
            errors++;
            return;
         end
         want = result_q.pop_front();
         bytes_seen++;
         check_field("payload_valid", want.payload_valid, got.payload_valid);
         check_field("payload_byte", want.payload_byte, got.payload_byte);
         check_field("frame_done", want.frame_done, got.frame_done);
         check_field("frame_status", want.frame_status, got.frame_status);
         check_field("frame_length", want.frame_length, got.frame_length);
         check_field("frame_sequence", want.frame_sequence, got.frame_sequence);
         check_field("frame_kind", want.frame_kind, got.frame_kind);
         if (want.frame_done) begin
            buffers_seen++;
            status_count[want.frame_status]++;
         end
      endfunction
   endclass

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_TRUNCATED,
      FRAME_TOO_LONG,
      FRAME_BAD_MARKER,
      FRAME_SHORT,
      FRAME_NOISE
   } frame_style_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fdsc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fdsc_pkg::rsp_type rsp_data;
   logic              csr_wen = 1'b0;
   logic              csr_index = 1'b0;
   logic [7:0]        csr_wdata = '0;

   deframer_scoreboard sb;
   logic [7:0]  frame_bytes[$];
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   int          stall_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned settings_used = 1;

   frame_deframer_sum_checksum uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watch both channels for transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // one byte transfer, with an optional gap ahead of it
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{rx_byte: value, buffer_end: last};
      bytes_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.result_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [7:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // build one buffer of the given kind; fixed_len < 0 picks a random length
   task automatic build_frame(input frame_style_type style, input int fixed_len);
      logic [7:0] limit;
      logic [7:0] seq_b;
      logic [7:0] kind_b;
      logic [7:0] csum;
      logic [7:0] b;
      logic [7:0] payload[$];
      int         len;
      int         body;
      int         extra;
      int         keep;
      limit = sb.limit_cfg;
      seq_b = 8'($urandom_range(0, 255));
      kind_b = 8'($urandom_range(0, 255));
      if (fixed_len >= 0) begin
         len = fixed_len;
      end else if ($urandom_range(0, 9) != 0) begin
         len = $urandom_range(0, (limit < 8'd16) ? int'(limit) : 16);
      end else begin
         len = $urandom_range(0, int'(limit));
      end
      body = len;
      extra = 0;
      case (style)
         FRAME_TOO_LONG: begin
            if (limit != 8'hFF) begin
               len = $urandom_range(int'(limit) + 1,
                                    (limit > 8'd239) ? 255 : int'(limit) + 16);
               body = $urandom_range(0, 4);
            end
         end
         FRAME_TRUNCATED: begin
            if (len == 0) len = 1;
            body = $urandom_range(0, len - 1);
         end
         FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_MARKER: begin
            if ($urandom_range(0, 3) == 0) extra = $urandom_range(1, 3);
         end
         default: ;
      endcase
      csum = 8'(len) + seq_b + kind_b;
      for (int i = 0; i < body; i++) begin
         b = 8'($urandom_range(0, 255));
         payload.push_back(b);
         csum += b;
      end
      if (style == FRAME_BAD_SUM) csum ^= 8'($urandom_range(1, 255));
      frame_bytes.delete();
      if (style == FRAME_BAD_MARKER) begin
         frame_bytes.push_back(sb.marker_cfg ^ 8'($urandom_range(1, 255)));
      end else begin
         frame_bytes.push_back(sb.marker_cfg);
      end
      frame_bytes.push_back(8'(len));
      frame_bytes.push_back(seq_b);
      frame_bytes.push_back(kind_b);
      frame_bytes.push_back(csum);
      foreach (payload[i]) frame_bytes.push_back(payload[i]);
      repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (style == FRAME_SHORT) begin
         keep = $urandom_range(1, 4);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end
      if (style == FRAME_NOISE) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic frame_style_type pick_style();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return FRAME_GOOD;
      if (r < 68) return FRAME_BAD_SUM;
      if (r < 75) return FRAME_TRUNCATED;
      if (r < 82) return FRAME_TOO_LONG;
      if (r < 88) return FRAME_BAD_MARKER;
      if (r < 94) return FRAME_SHORT;
      return FRAME_NOISE;
   endfunction

   // run ends here if the block stops answering
   initial begin
      #5_000_000;
      $display("[frame_deframer_sum_checksum] ERROR");
      $finish;
   end

   initial begin
      int unsigned phase_end;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed buffers under reset settings
      // good frame with all-ones payload and one trailing byte
      frame_bytes = '{8'h7E, 8'h01, 8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'h00};
      send_frame();
      // buffer of one byte
      frame_bytes = '{8'hFF};
      send_frame();
      // wrong start marker
      frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // length one above the limit, also cut short
      frame_bytes = '{8'h7E, 8'h41, 8'h00, 8'h00, 8'h41};
      send_frame();
      // payload cut short
      frame_bytes = '{8'h7E, 8'h03, 8'h01, 8'h02, 8'h06, 8'hAA};
      send_frame();
      // checksum mismatch
      frame_bytes = '{8'h7E, 8'h00, 8'h12, 8'h34, 8'h00};
      send_frame();

      // random phases, each under its own register setting
      for (int phase = 0; phase < 10; phase++) begin
         drain();
         case (phase)
            0: begin
               write_reg(fdsc_pkg::CSR_START_MARKER, 8'h00);
               write_reg(fdsc_pkg::CSR_MAX_PAYLOAD, 8'h00);
            end
            1: begin
               write_reg(fdsc_pkg::CSR_START_MARKER, 8'hFF);
               write_reg(fdsc_pkg::CSR_MAX_PAYLOAD, 8'hFF);
            end
            2: begin
               write_reg(fdsc_pkg::CSR_START_MARKER, fdsc_pkg::START_MARKER_RESET);
               write_reg(fdsc_pkg::CSR_MAX_PAYLOAD, fdsc_pkg::MAX_PAYLOAD_RESET);
            end
            default: begin
               write_reg(fdsc_pkg::CSR_START_MARKER, 8'($urandom_range(0, 255)));
               write_reg(fdsc_pkg::CSR_MAX_PAYLOAD, ($urandom_range(0, 3) == 0) ?
                         8'($urandom_range(0, 255)) : 8'($urandom_range(0, 24)));
            end
         endcase
         settings_used++;
         gaps_on = (phase != 9) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase != 9) && ($urandom_range(0, 3) != 0);
         phase_end = bytes_sent + 55;
         while (bytes_sent < phase_end) begin
            build_frame(pick_style(), -1);
            send_frame();
         end
         if (phase == 1) begin
            // longest payload, then enough trailing bytes to pin the position
            build_frame(FRAME_GOOD, 255);
            while (frame_bytes.size() < 520) begin
               frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_frame();
         end
      end
      drain();

      $display("covered %0d byte transfers in %0d buffers over %0d register settings",
               sb.bytes_seen, sb.buffers_seen, settings_used);
      $display("status mix: ok %0d, short %0d, bad marker %0d, too long %0d, %s %0d, %s %0d",
               sb.status_count[fdsc_pkg::STATUS_OK],
               sb.status_count[fdsc_pkg::STATUS_SHORT],
               sb.status_count[fdsc_pkg::STATUS_BAD_MARK],
               sb.status_count[fdsc_pkg::STATUS_TOO_LONG],
               "truncated", sb.status_count[fdsc_pkg::STATUS_TRUNCATED],
               "checksum", sb.status_count[fdsc_pkg::STATUS_CHECKSUM]);
      if (sb.errors == 0 && sb.result_q.size() == 0) begin
         $display("[frame_deframer_sum_checksum] OK");
      end else begin
         $display("[frame_deframer_sum_checksum] ERROR");
      end
      $finish;
   end

endmodule
